// File: sv/octree_box_cell_index_unit_defines.svh
// Assertion macros shared by the octree box cell index unit.
`ifndef OCTREE_BOX_CELL_INDEX_UNIT_DEFINES_SVH
`define OCTREE_BOX_CELL_INDEX_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define OBCI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define OBCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/obci_pkg.sv
package obci_pkg;

    localparam int MAX_LEVEL_DEF = 7;
    localparam int LEVEL_W       = 3;
    localparam int COORD_W       = 32;
    localparam int INDEX_W       = 22;
    localparam int NUM_AXES      = 3;
    localparam int NUM_COORDS    = 2 * NUM_AXES;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 32;

    localparam logic [COORD_W-1:0] SCALE_RESET = 32'h0001_0000;

    typedef enum logic [2:0] {
        REG_TREE_LEVEL = 3'd0,
        REG_ORIGIN_X   = 3'd1,
        REG_ORIGIN_Y   = 3'd2,
        REG_ORIGIN_Z   = 3'd3,
        REG_SCALE_X    = 3'd4,
        REG_SCALE_Y    = 3'd5,
        REG_SCALE_Z    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } box_t;

    typedef struct packed {
        logic [INDEX_W-1:0] cell_index;
        logic [LEVEL_W-1:0] cell_level;
        logic               clamped;
    } cell_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]        tree_level;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic [COORD_W-1:0]        scale_x;
        logic [COORD_W-1:0]        scale_y;
        logic [COORD_W-1:0]        scale_z;
    } cfg_t;

    // Quantizer output for one coordinate: integer part of the scaled
    // offset, whether the offset was negative, and whether that counts as
    // a saturation (it does not when the scale is zero).
    typedef struct packed {
        logic [COORD_W-1:0] ip;
        logic               neg;
        logic               flag;
    } quant_t;

    // Number of cells in all levels above the given depth: (8^depth - 1) / 7.
    function automatic logic [INDEX_W-1:0] cell_offset(input logic [LEVEL_W-1:0] depth);
        logic [INDEX_W-1:0] offs;
        case (depth)
            3'd0:    offs = 22'd0;
            3'd1:    offs = 22'd1;
            3'd2:    offs = 22'd9;
            3'd3:    offs = 22'd73;
            3'd4:    offs = 22'd585;
            3'd5:    offs = 22'd4681;
            3'd6:    offs = 22'd37449;
            3'd7:    offs = 22'd299593;
            default: offs = 22'd0;
        endcase
        return offs;
    endfunction

endpackage

// File: sv/obci_regs.sv
module obci_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [obci_pkg::PADDR_W-1:0]  paddr,
    input  logic [obci_pkg::PDATA_W-1:0]  pwdata,
    output logic [obci_pkg::PDATA_W-1:0]  prdata,
    output obci_pkg::cfg_t                cfg
);
    import obci_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    // Registers are word aligned; the two low address bits are not decoded.
    assign idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_TREE_LEVEL: cfg_next.tree_level = pwdata[LEVEL_W-1:0];
                REG_ORIGIN_X:   cfg_next.origin_x   = pwdata;
                REG_ORIGIN_Y:   cfg_next.origin_y   = pwdata;
                REG_ORIGIN_Z:   cfg_next.origin_z   = pwdata;
                REG_SCALE_X:    cfg_next.scale_x    = pwdata;
                REG_SCALE_Y:    cfg_next.scale_y    = pwdata;
                REG_SCALE_Z:    cfg_next.scale_z    = pwdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TREE_LEVEL: prdata = PDATA_W'(cfg_reg.tree_level);
            REG_ORIGIN_X:   prdata = cfg_reg.origin_x;
            REG_ORIGIN_Y:   prdata = cfg_reg.origin_y;
            REG_ORIGIN_Z:   prdata = cfg_reg.origin_z;
            REG_SCALE_X:    prdata = cfg_reg.scale_x;
            REG_SCALE_Y:    prdata = cfg_reg.scale_y;
            REG_SCALE_Z:    prdata = cfg_reg.scale_z;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tree_level <= '0;
            cfg_reg.origin_x   <= '0;
            cfg_reg.origin_y   <= '0;
            cfg_reg.origin_z   <= '0;
            cfg_reg.scale_x    <= SCALE_RESET;
            cfg_reg.scale_y    <= SCALE_RESET;
            cfg_reg.scale_z    <= SCALE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/obci_quant.sv
module obci_quant (
    input  logic                               clk,
    input  logic                               diff_en,
    input  logic                               prod_en,
    input  logic signed [obci_pkg::COORD_W-1:0] pos,
    input  logic signed [obci_pkg::COORD_W-1:0] org,
    input  logic [obci_pkg::COORD_W-1:0]       scl,
    output obci_pkg::quant_t                   q
);
    import obci_pkg::*;

    logic [COORD_W:0]     diff;
    logic [COORD_W-1:0]   mag_reg;
    logic                 neg_reg;
    logic                 flag_reg;
    logic [2*COORD_W-1:0] prod;
    quant_t               q_reg;

    // The offset from the origin is an exact 33-bit signed value. When it
    // is not negative it fits in 32 unsigned bits.
    assign diff = {pos[COORD_W-1], pos} - {org[COORD_W-1], org};

    always_ff @(posedge clk)
    begin
        if (diff_en)
        begin
            mag_reg  <= diff[COORD_W-1:0];
            neg_reg  <= diff[COORD_W];
            flag_reg <= diff[COORD_W] && (scl != '0);
        end
    end

    assign prod = {{COORD_W{1'b0}}, mag_reg} * {{COORD_W{1'b0}}, scl};

    always_ff @(posedge clk)
    begin
        if (prod_en)
        begin
            q_reg.ip   <= prod[2*COORD_W-1:COORD_W];
            q_reg.neg  <= neg_reg;
            q_reg.flag <= flag_reg;
        end
    end

    assign q = q_reg;

endmodule

// File: sv/obci_encode.sv
module obci_encode #(
    parameter int MAX_LEVEL = obci_pkg::MAX_LEVEL_DEF
) (
    input  obci_pkg::quant_t [obci_pkg::NUM_COORDS-1:0] q,
    input  logic [obci_pkg::LEVEL_W-1:0]                lv,
    output obci_pkg::cell_t                             res
);
    import obci_pkg::*;

    localparam int CW  = MAX_LEVEL;
    localparam int MW  = NUM_AXES * CW;
    localparam int UPW = $clog2(MAX_LEVEL + 1);

    logic [COORD_W-1:0]    cap_full;
    logic [CW-1:0]         cap;
    logic [CW-1:0]         coord [NUM_COORDS];
    logic [NUM_COORDS-1:0] sat;
    logic [NUM_COORDS-1:0] neg_flag;
    logic [MW-1:0]         code_lo;
    logic [MW-1:0]         code_hi;
    logic [MW-1:0]         code_diff;
    logic [UPW-1:0]        up;
    logic [LEVEL_W-1:0]    depth;
    logic [COORD_W-1:0]    hi_shift;

    always_comb
    begin
        cap_full = (COORD_W'(1) << lv) - COORD_W'(1);
        cap      = CW'(cap_full);

        // Saturate each coordinate to the leaf grid of the level in use.
        for (int k = 0; k < NUM_COORDS; k++)
        begin
            neg_flag[k] = q[k].flag;
            if (q[k].neg)
            begin
                coord[k] = '0;
                sat[k]   = 1'b0;
            end
            else if ((q[k].ip & ~cap_full) != '0)
            begin
                coord[k] = cap;
                sat[k]   = 1'b1;
            end
            else
            begin
                coord[k] = CW'(q[k].ip);
                sat[k]   = 1'b0;
            end
        end

        // Morton interleave: x in bit 0, y in bit 1, z in bit 2 of each triple.
        for (int i = 0; i < CW; i++)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                code_lo[NUM_AXES*i + a] = coord[a][i];
                code_hi[NUM_AXES*i + a] = coord[a + NUM_AXES][i];
            end
        end

        // The highest differing triple sets how many levels the box climbs.
        code_diff = code_lo ^ code_hi;
        up        = '0;
        for (int i = 0; i < CW; i++)
        begin
            if (code_diff[NUM_AXES*i +: NUM_AXES] != '0)
            begin
                up = UPW'(i + 1);
            end
        end

        depth    = lv - LEVEL_W'(up);
        hi_shift = COORD_W'(code_hi) >> (NUM_AXES * up);

        res.cell_index = INDEX_W'(hi_shift) + cell_offset(depth);
        res.cell_level = depth;
        res.clamped    = (sat != '0) || (neg_flag != '0);
    end

endmodule

// File: sv/octree_box_cell_index_unit.sv
// Octree box cell index unit.
// A box transaction (min and max corners, signed Q16.16) enters on the box
// channel; the cell channel returns one transaction per box carrying the
// linear octree index of the smallest cell that holds the whole box, that
// cell's depth, and a flag that is set when any corner coordinate had to be
// saturated into the region. The region origin, per-axis scale and tree
// level are set through the APB port and are to be changed only while idle;
// the block itself does not enforce this. A box passes through the input
// register, offset subtract, 32x32 multiply, then saturate/interleave/level
// search into the result register. Throughput is one box per cycle while
// the cell channel does not stall.
// Reset clears all valid flags and restores the registers to level 0,
// origin 0 and scale 1.0. When the cell channel stalls, the result holds and
// the stages behind it keep filling; box_stall rises only once all four
// stages hold a transaction and the head is stalled.
module octree_box_cell_index_unit #(
    parameter int MAX_LEVEL = obci_pkg::MAX_LEVEL_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [obci_pkg::PADDR_W-1:0] paddr,
    input  logic [obci_pkg::PDATA_W-1:0] pwdata,
    output logic [obci_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         box_valid,
    output logic                         box_stall,
    input  obci_pkg::box_t               box,
    output logic                         cell_valid,
    input  logic                         cell_stall,
    output obci_pkg::cell_t              cell_data
);
    import obci_pkg::*;

    `include "octree_box_cell_index_unit_defines.svh"

    cfg_t cfg;

    // Stage valid flags: input register, offset register, product register
    // and result register.
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic v0_next, v1_next, v2_next, v3_next;
    logic en0, en1, en2, en3;

    box_t  box_reg;
    cell_t cell_reg;
    cell_t cell_next;

    logic signed [COORD_W-1:0] pos [NUM_COORDS];
    logic signed [COORD_W-1:0] org [NUM_AXES];
    logic [COORD_W-1:0]        scl [NUM_AXES];
    quant_t [NUM_COORDS-1:0]   q;
    logic [LEVEL_W-1:0]        lv;

    assign pready = 1'b1;

    obci_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // A stage may load when it is empty or when its own contents move on,
    // so bubbles are squeezed out even while the result is held.
    assign en3       = !v3_reg || !cell_stall;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign en0       = !v0_reg || en1;
    assign box_stall = !en0;

    always_comb
    begin
        v0_next = en0 ? box_valid : v0_reg;
        v1_next = en1 ? v0_reg : v1_reg;
        v2_next = en2 ? v1_reg : v2_reg;
        v3_next = en3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            box_reg <= box;
        end
    end

    // The six coordinates in order min x, y, z then max x, y, z; each pairs
    // with the origin and scale of its axis.
    assign pos[0] = box_reg.min_x;
    assign pos[1] = box_reg.min_y;
    assign pos[2] = box_reg.min_z;
    assign pos[3] = box_reg.max_x;
    assign pos[4] = box_reg.max_y;
    assign pos[5] = box_reg.max_z;
    assign org[0] = cfg.origin_x;
    assign org[1] = cfg.origin_y;
    assign org[2] = cfg.origin_z;
    assign scl[0] = cfg.scale_x;
    assign scl[1] = cfg.scale_y;
    assign scl[2] = cfg.scale_z;

    for (genvar k = 0; k < NUM_COORDS; k++)
    begin : g_quant
        obci_quant u_quant (
            .clk     (clk),
            .diff_en (en1),
            .prod_en (en2),
            .pos     (pos[k]),
            .org     (org[k % NUM_AXES]),
            .scl     (scl[k % NUM_AXES]),
            .q       (q[k])
        );
    end

    // A programmed level deeper than the tree supports is used as the
    // deepest level.
    always_comb
    begin
        if (32'(cfg.tree_level) > 32'(MAX_LEVEL))
        begin
            lv = LEVEL_W'(MAX_LEVEL);
        end
        else
        begin
            lv = cfg.tree_level;
        end
    end

    obci_encode #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_encode (
        .q   (q),
        .lv  (lv),
        .res (cell_next)
    );

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_valid = v3_reg;
    assign cell_data  = cell_reg;

    // The input side only stalls when every stage is occupied and the head
    // transaction is held by the receiver.
    `OBCI_ASSERT_NOW(a_stall_full, clk, rst_n, box_stall,
        v0_reg && v1_reg && v2_reg && v3_reg && cell_stall,
        "box_stall raised while the pipeline has a free stage")

    // The chosen cell can never lie deeper than the level in use.
    `OBCI_ASSERT_NOW(a_level_bound, clk, rst_n, cell_valid, cell_data.cell_level <= lv,
        "cell_level deeper than the tree level in use")

    // With no subdivision every box lands in the root cell.
    `OBCI_ASSERT_NOW(a_root_only, clk, rst_n, cell_valid && (lv == '0),
        (cell_data.cell_index == '0) && (cell_data.cell_level == '0),
        "non-root cell reported at tree level zero")

    // A result that is taken while nothing moves up behind it leaves the
    // output empty in the next cycle.
    `OBCI_ASSERT_NEXT(a_drain, clk, rst_n, cell_valid && !cell_stall && !v2_reg,
        !cell_valid, "result repeated after it was taken")

endmodule
